@@ sv/windowed_moving_average_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the windowed moving average
// Shared property shapes, each clocked on the rising edge and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_MOVING_AVERAGE_MACROS_SVH
`define WINDOWED_MOVING_AVERAGE_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define WMA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define WMA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define WMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/wma_pkg.sv @@
// ----------------------------------------------------------------------------
// Windowed moving average package
// Shared constants, register addresses and types of the averaging block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wma_pkg;

   // Default sizes of the design.
   localparam int WINDOW_MAX_DEF  = 64;
   localparam int SAMPLE_BITS_DEF = 16;

   // Fixed widths of the configuration registers and the sample counter.
   localparam int WIN_REG_W   = 7;
   localparam int CNT_W       = 16;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // Register byte addresses.
   localparam logic [CSR_ADDR_W-1:0] ADDR_WINDOW_SIZE = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_SEND_COUNT  = 3'd4;

   // Register reset values.
   localparam logic [WIN_REG_W-1:0] WINDOW_SIZE_RESET = 7'd8;
   localparam logic [CNT_W-1:0]     SEND_COUNT_RESET  = 16'd10;

   // Queue status seen by both of its neighbors.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Sequencer of the back part.
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_DIV
   } back_state_type;

endpackage

`default_nettype wire

@@ sv/wma_front.sv @@
// ----------------------------------------------------------------------------
// Windowed moving average front
// Accepts request words, runs the saturating sample counter and queues each
// sample together with its report-due flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wma_front #(
   parameter int SAMPLE_BITS = wma_pkg::SAMPLE_BITS_DEF,
   localparam int REQ_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_tvalid,
   output logic                          req_tready,
   input  wire  [REQ_DATA_W-1:0]         req_tdata,   // [SAMPLE_BITS-1:0] sample
   input  wire                           req_tuser,   // [0] restart_count
   input  wire  [wma_pkg::CNT_W-1:0]     send_count_i,
   input  wma_pkg::queue_status_type     q_status_i,
   output logic                          push_o,
   output logic [SAMPLE_BITS:0]          push_data_o
);

   import wma_pkg::*;

   localparam logic [CNT_W-1:0] CNT_TOP = '1;

   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic [CNT_W-1:0] cnt_base;
   logic [CNT_W-1:0] cnt_next;
   logic             accept;
   logic             send_due;

   // A word is taken whenever the queue has room and reset is released.
   assign req_tready = !q_status_i.full && !reset;
   assign accept     = req_tvalid && req_tready;

   // Optional restart, then a saturating increment and the due compare.
   always_comb begin
      cnt_base = req_tuser ? '0 : cnt_ff;
      cnt_next = (cnt_base == CNT_TOP) ? cnt_base : cnt_base + CNT_W'(1);
      send_due = (cnt_next >= send_count_i);
      cnt_in   = accept ? cnt_next : cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Queue entry: sample above the due flag.
   assign push_o      = accept;
   assign push_data_o = {req_tdata[SAMPLE_BITS-1:0], send_due};

endmodule

`default_nettype wire

@@ sv/wma_fifo.sv @@
// ----------------------------------------------------------------------------
// Windowed moving average queue
// Short first-in first-out buffer that decouples the front from the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "windowed_moving_average_macros.svh"

module wma_fifo #(
   parameter int WIDTH = 17,
   parameter int DEPTH = wma_pkg::QUEUE_DEPTH
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push_i,
   input  wire  [WIDTH-1:0]           push_data_i,
   input  wire                        pop_i,
   output logic [WIDTH-1:0]           pop_data_o,
   output wma_pkg::queue_status_type  status_o
);

   import wma_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // Pointer wrap and occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_i) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_i) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_i && !push_i) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push_i) begin
         store_ff[wr_ptr_ff] <= push_data_i;
      end
   end

   assign pop_data_o      = store_ff[rd_ptr_ff];
   assign status_o.full   = (count_ff == CNT_W'(DEPTH));
   assign status_o.empty  = (count_ff == '0);

   `WMA_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "queue overfilled")
   `WMA_ASSERT_SAME(a_no_push_full, clock, reset, push_i, !status_o.full, "push into full queue")
   `WMA_ASSERT_SAME(a_no_pop_empty, clock, reset, pop_i, !status_o.empty, "pop from empty queue")

endmodule

`default_nettype wire

@@ sv/wma_div.sv @@
// ----------------------------------------------------------------------------
// Windowed moving average divider
// Restoring divider, one quotient bit per cycle; divides the signed window sum
// by the fill level and truncates toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wma_div #(
   parameter int SUM_W  = 23,
   parameter int HELD_W = 7,
   parameter int QUO_W  = 16
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start_i,
   input  wire  signed [SUM_W-1:0]  dividend_i,
   input  wire  [HELD_W-1:0]        divisor_i,
   output logic                     done_o,
   output logic [QUO_W-1:0]         quotient_o
);

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic              busy_ff;
   logic              busy_in;
   logic              done_ff;
   logic              done_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic [HELD_W-1:0] rem_ff;
   logic [HELD_W-1:0] rem_in;
   logic [SUM_W-1:0]  quo_ff;
   logic [SUM_W-1:0]  quo_in;
   logic              neg_ff;
   logic              neg_in;
   logic [HELD_W-1:0] dsor_ff;
   logic [HELD_W-1:0] dsor_in;
   logic [HELD_W:0]   rem_sh;
   logic              fits;
   logic [HELD_W:0]   rem_sub;
   logic [QUO_W-1:0]  quo_low;

   // One restoring step on the magnitude.
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[SUM_W-1]};
      fits    = (rem_sh >= {1'b0, dsor_ff});
      rem_sub = fits ? (rem_sh - {1'b0, dsor_ff}) : rem_sh;
   end

   // Load on start, iterate while busy.
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      dsor_in = dsor_ff;
      if (start_i) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         step_in = STEP_W'(SUM_W);
         rem_in  = '0;
         neg_in  = dividend_i[SUM_W-1];
         quo_in  = dividend_i[SUM_W-1] ? (~dividend_i + SUM_W'(1)) : dividend_i;
         dsor_in = divisor_i;
      end else if (busy_ff) begin
         rem_in  = rem_sub[HELD_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
      dsor_ff <= dsor_in;
   end

   // Restore the sign; the quotient always fits the sample width.
   assign quo_low    = quo_ff[QUO_W-1:0];
   assign quotient_o = neg_ff ? (~quo_low + QUO_W'(1)) : quo_low;
   assign done_o     = done_ff;

endmodule

`default_nettype wire

@@ sv/wma_back.sv @@
// ----------------------------------------------------------------------------
// Windowed moving average back
// Keeps the sample ring and running sum, divides by the fill level and holds
// the result word until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "windowed_moving_average_macros.svh"

module wma_back #(
   parameter int WINDOW_MAX  = wma_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = wma_pkg::SAMPLE_BITS_DEF,
   localparam int HELD_W     = $clog2(WINDOW_MAX + 1)
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire  [wma_pkg::WIN_REG_W-1:0]  window_size_i,
   input  wire                            win_clear_i,
   input  wma_pkg::queue_status_type      q_status_i,
   output logic                           pop_o,
   input  wire  [SAMPLE_BITS:0]           pop_data_i,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   output logic [SAMPLE_BITS-1:0]         average_o,
   output logic [HELD_W-1:0]              held_o,
   output logic                           send_due_o
);

   import wma_pkg::*;

   localparam int IDX_W = $clog2(WINDOW_MAX);
   localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_MAX) + 1;
   localparam int CMP_W = (WIN_REG_W > HELD_W) ? WIN_REG_W : HELD_W;

   back_state_type           state_ff;
   back_state_type           state_in;

   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  sum_in;
   logic [IDX_W-1:0]         head_ff;
   logic [IDX_W-1:0]         head_in;
   logic [HELD_W-1:0]        fill_ff;
   logic [HELD_W-1:0]        fill_in;

   logic [IDX_W-1:0]         slot_ff;
   logic [IDX_W-1:0]         slot_in;
   logic [SAMPLE_BITS-1:0]   sample_ff;
   logic                     due_ff;

   logic [SAMPLE_BITS-1:0]   ring_mem [WINDOW_MAX];
   logic [SAMPLE_BITS-1:0]   ring_rdata_ff;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [SAMPLE_BITS-1:0]   avg_ff;
   logic [HELD_W-1:0]        held_ff;
   logic                     rsp_due_ff;

   logic [CMP_W-1:0]         win_ext;
   logic [HELD_W-1:0]        win_eff;
   logic                     full;
   logic [SAMPLE_BITS-1:0]   old_sample;
   logic signed [SUM_W-1:0]  old_ext;
   logic signed [SUM_W-1:0]  new_ext;
   logic signed [SUM_W-1:0]  sum_new;
   logic [HELD_W-1:0]        fill_new;
   logic [HELD_W-1:0]        slot_plus;
   logic [IDX_W-1:0]         head_new;

   logic                     ring_we;
   logic                     div_start;
   logic                     div_done;
   logic [SAMPLE_BITS-1:0]   div_quo;
   logic                     out_free;
   logic                     out_load;

   // Window size as used: zero counts as one, oversize clamps to the ring depth.
   always_comb begin
      win_ext = CMP_W'(window_size_i);
      if (window_size_i == '0) begin
         win_eff = HELD_W'(1);
      end else if (win_ext > CMP_W'(WINDOW_MAX)) begin
         win_eff = HELD_W'(WINDOW_MAX);
      end else begin
         win_eff = HELD_W'(win_ext);
      end
   end

   // Slot to overwrite for a newly popped sample.
   assign slot_in = (HELD_W'(head_ff) >= win_eff) ? '0 : head_ff;

   // Sum and fill update, evaluated while the old ring entry is at hand.
   always_comb begin
      full       = (fill_ff >= win_eff);
      old_sample = full ? ring_rdata_ff : '0;
      old_ext    = {{(SUM_W - SAMPLE_BITS){old_sample[SAMPLE_BITS-1]}}, old_sample};
      new_ext    = {{(SUM_W - SAMPLE_BITS){sample_ff[SAMPLE_BITS-1]}}, sample_ff};
      sum_new    = sum_ff - old_ext + new_ext;
      fill_new   = full ? win_eff : fill_ff + HELD_W'(1);
      slot_plus  = HELD_W'(slot_ff) + HELD_W'(1);
      head_new   = (slot_plus >= win_eff) ? '0 : IDX_W'(slot_plus);
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_status_i.empty) begin
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            state_in = BK_DIV;
         end
         BK_DIV: begin
            if (div_done && out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      pop_o     = 1'b0;
      ring_we   = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            pop_o = !q_status_i.empty;
         end
         BK_READ: begin
            ring_we   = 1'b1;
            div_start = 1'b1;
         end
         BK_DIV: begin
            out_load = div_done && out_free;
         end
         default: begin
            pop_o = 1'b0;
         end
      endcase
   end

   // Window state: emptied by a window size write, advanced once per sample.
   always_comb begin
      sum_in  = sum_ff;
      head_in = head_ff;
      fill_in = fill_ff;
      if (win_clear_i) begin
         sum_in  = '0;
         head_in = '0;
         fill_in = '0;
      end else if (ring_we) begin
         sum_in  = sum_new;
         head_in = head_new;
         fill_in = fill_new;
      end
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         sum_ff       <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item and result payload.
   always_ff @(posedge clock) begin
      if (pop_o) begin
         slot_ff   <= slot_in;
         sample_ff <= pop_data_i[SAMPLE_BITS:1];
         due_ff    <= pop_data_i[0];
      end
      if (out_load) begin
         avg_ff     <= div_quo;
         held_ff    <= fill_ff;
         rsp_due_ff <= due_ff;
      end
   end

   // Sample ring: read the slot on pop, write it in the following cycle.
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[slot_ff] <= sample_ff;
      end
      ring_rdata_ff <= ring_mem[slot_in];
   end

   wma_div #(
      .SUM_W  (SUM_W),
      .HELD_W (HELD_W),
      .QUO_W  (SAMPLE_BITS)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .start_i    (div_start),
      .dividend_i (sum_new),
      .divisor_i  (fill_new),
      .done_o     (div_done),
      .quotient_o (div_quo)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign average_o  = avg_ff;
   assign held_o     = held_ff;
   assign send_due_o = rsp_due_ff;

   `WMA_ASSERT_ALWAYS(a_fill_in_window, clock, reset, fill_ff <= win_eff, "fill level above window")
   `WMA_ASSERT_ALWAYS(a_head_in_window, clock, reset, HELD_W'(head_ff) < win_eff, "ring head outside window")
   `WMA_ASSERT_NEXT(a_read_then_div, clock, reset, state_ff == BK_READ, (state_ff == BK_DIV) && !div_done, "divider not started after ring read")

endmodule

`default_nettype wire

@@ sv/windowed_moving_average.sv @@
// ----------------------------------------------------------------------------
// Windowed moving average
// Running mean of the most recent samples, with a report-due flag paced by a
// saturating sample counter.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel carries one signed sample per word in req_tdata and a
//   counter restart flag in req_tuser. Every request word yields exactly one
//   response word: the truncated mean of the samples in the window and the
//   number held, in rsp_tdata, and the report-due flag in rsp_tuser.
//   In the back part each word is popped from the queue as the oldest ring
//   entry is read; then the sum is updated and the ring written; then the
//   one-bit-per-cycle divider runs; then the response register is loaded.
//   That divider sets the throughput: the back takes its next word from the
//   queue only after the previous result is loaded.
//   A two-entry queue lets the front keep taking words while the back works;
//   req_tready drops only when the queue is full or reset is asserted.
//   A stalled receiver holds the response register; the back then waits with
//   its next result in the divider, and the queue fills behind it.
//   Reset empties the window, clears the sample counter and the queue, and
//   loads window_size = 8 and send_count = 10. Writing window_size empties the
//   window; write the registers only while no word is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module windowed_moving_average #(
   parameter int WINDOW_MAX  = wma_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = wma_pkg::SAMPLE_BITS_DEF,
   localparam int HELD_W     = $clog2(WINDOW_MAX + 1),
   localparam int REQ_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_W = ((SAMPLE_BITS + HELD_W + 7) / 8) * 8
) (
   input  wire                               clock,
   input  wire                               reset,
   // Request channel.
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [REQ_DATA_W-1:0]             req_tdata,   // [SAMPLE_BITS-1:0] sample
   input  wire                               req_tuser,   // [0] restart_count
   // Response channel.
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [RSP_DATA_W-1:0]             rsp_tdata,   // average, then samples_held
   output logic                              rsp_tuser,   // [0] send_due
   // Register port.
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire  [wma_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire  [wma_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [wma_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   import wma_pkg::*;

   logic [WIN_REG_W-1:0]    window_size_ff;
   logic [WIN_REG_W-1:0]    window_size_in;
   logic [CNT_W-1:0]        send_count_ff;
   logic [CNT_W-1:0]        send_count_in;
   logic                    csr_write;
   logic                    win_clear;

   queue_status_type        q_status;
   logic                    push;
   logic [SAMPLE_BITS:0]    push_data;
   logic                    pop;
   logic [SAMPLE_BITS:0]    pop_data;

   logic [SAMPLE_BITS-1:0]  average;
   logic [HELD_W-1:0]       samples_held;
   logic                    send_due;

   // Register writes complete in the access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign win_clear  = csr_write && (csr_paddr == ADDR_WINDOW_SIZE);

   always_comb begin
      window_size_in = window_size_ff;
      send_count_in  = send_count_ff;
      if (csr_write) begin
         case (csr_paddr)
            ADDR_WINDOW_SIZE: window_size_in = csr_pwdata[WIN_REG_W-1:0];
            ADDR_SEND_COUNT:  send_count_in  = csr_pwdata[CNT_W-1:0];
            default:          window_size_in = window_size_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_SIZE_RESET;
         send_count_ff  <= SEND_COUNT_RESET;
      end else begin
         window_size_ff <= window_size_in;
         send_count_ff  <= send_count_in;
      end
   end

   // Register read back.
   always_comb begin
      case (csr_paddr)
         ADDR_WINDOW_SIZE: csr_prdata = CSR_DATA_W'(window_size_ff);
         ADDR_SEND_COUNT:  csr_prdata = CSR_DATA_W'(send_count_ff);
         default:          csr_prdata = '0;
      endcase
   end

   wma_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .send_count_i (send_count_ff),
      .q_status_i   (q_status),
      .push_o       (push),
      .push_data_o  (push_data)
   );

   wma_fifo #(
      .WIDTH (SAMPLE_BITS + 1),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_i      (push),
      .push_data_i (push_data),
      .pop_i       (pop),
      .pop_data_o  (pop_data),
      .status_o    (q_status)
   );

   wma_back #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .window_size_i (window_size_ff),
      .win_clear_i   (win_clear),
      .q_status_i    (q_status),
      .pop_o         (pop),
      .pop_data_i    (pop_data),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .average_o     (average),
      .held_o        (samples_held),
      .send_due_o    (send_due)
   );

   // Response word: average in the low bits, samples held above, zero filled.
   assign rsp_tdata = RSP_DATA_W'({samples_held, average});
   assign rsp_tuser = send_due;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Windowed moving average testbench
// Sends signed samples with counter restart flags through the request stream
// and checks every response word against a predictor kept in step with the
// block's window, running sum, sample counter and registers. Registers are
// changed between phases while nothing is in flight and read back each time.
// Both streams idle at random, apart from a quiet phase without idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import wma_pkg::*;

   localparam int WIN_CAP       = WINDOW_MAX_DEF;
   localparam int REQ_W         = 16;
   localparam int RSP_W         = 24;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_ITEMS  = 690;
   localparam logic [CNT_W-1:0] COUNT_TOP = '1;

   // One expected response word.
   typedef struct packed {
      logic signed [15:0]   average;
      logic [WIN_REG_W-1:0] held;
      logic                 due;
   } mean_word_type;

   // Predicts each response word and compares it with what the block sends.
   class mean_scoreboard;
      logic signed [15:0]   ring [WIN_CAP];
      longint               window_total;
      int                   head;
      int                   fill;
      logic [CNT_W-1:0]     sample_count;
      logic [WIN_REG_W-1:0] window_reg;
      logic [CNT_W-1:0]     send_reg;
      mean_word_type        pending [$];
      int                   errors;

      function new();
         window_total = 0;
         head         = 0;
         fill         = 0;
         sample_count = '0;
         window_reg   = WINDOW_SIZE_RESET;
         send_reg     = SEND_COUNT_RESET;
         errors       = 0;
      endfunction

      // A write of the window size also empties the window.
      function void write_register(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
         if (addr == ADDR_WINDOW_SIZE) begin
            window_reg   = data[WIN_REG_W-1:0];
            window_total = 0;
            head         = 0;
            fill         = 0;
         end else if (addr == ADDR_SEND_COUNT) begin
            send_reg = data[CNT_W-1:0];
         end
      endfunction

      function logic [CSR_DATA_W-1:0] register_value(logic [CSR_ADDR_W-1:0] addr);
         if (addr == ADDR_WINDOW_SIZE)
            return CSR_DATA_W'(window_reg);
         return CSR_DATA_W'(send_reg);
      endfunction

      // Advance the window by one accepted sample and queue the expected word.
      function void note_sample(logic signed [15:0] value, logic restart);
         int            span;
         mean_word_type word;
         span = (window_reg == 0) ? 1 : (window_reg > WIN_CAP) ? WIN_CAP : int'(window_reg);
         if (restart)
            sample_count = '0;
         if (sample_count != COUNT_TOP)
            sample_count = sample_count + 1'b1;
         if (head >= span)
            head = 0;
         // A full window drops its oldest sample first.
         if (fill >= span) begin
            window_total -= ring[head];
            fill = span;
         end else begin
            fill++;
         end
         ring[head] = value;
         window_total += value;
         head = (head + 1 >= span) ? 0 : head + 1;
         word.average = 16'(window_total / longint'(fill));
         word.held    = WIN_REG_W'(fill);
         word.due     = (sample_count >= send_reg);
         pending.push_back(word);
      endfunction

      // Compare one response word with the oldest expectation.
      function void check_word(logic [RSP_W-1:0] data, logic user);
         mean_word_type word;
         if (pending.size() == 0) begin
            $display("%0t: response word with none expected, tdata=%h tuser=%b",
                     $time, data, user);
            errors++;
            return;
         end
         word = pending.pop_front();
         if ($signed(data[15:0]) !== word.average) begin
            $display("%0t: average expected %0d, actual %0d",
                     $time, word.average, $signed(data[15:0]));
            errors++;
         end
         if (data[22:16] !== word.held) begin
            $display("%0t: samples_held expected %0d, actual %0d",
                     $time, word.held, data[22:16]);
            errors++;
         end
         if (user !== word.due) begin
            $display("%0t: send_due expected %b, actual %b", $time, word.due, user);
            errors++;
         end
         if (data[RSP_W-1] !== 1'b0) begin
            $display("%0t: tdata pad bit expected 0, actual %b", $time, data[RSP_W-1]);
            errors++;
         end
      endfunction
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic [REQ_W-1:0]      req_tdata   = '0;
   logic                  req_tuser   = 1'b0;
   logic                  rsp_tready  = 1'b0;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   wire                   req_tready;
   wire                   rsp_tvalid;
   wire [RSP_W-1:0]       rsp_tdata;
   wire                   rsp_tuser;
   wire [CSR_DATA_W-1:0]  csr_prdata;
   wire                   csr_pready;

   mean_scoreboard board;
   bit             calm = 1'b0;
   int             quiet_cycles = 0;

   windowed_moving_average dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // [15:0] sample
      .req_tuser   (req_tuser),    // [0] restart_count
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // [15:0] average, [22:16] samples_held, [23] zero
      .rsp_tuser   (rsp_tuser),    // [0] send_due
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side: check each accepted word and stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_word(rsp_tdata, rsp_tuser);
      rsp_tready <= calm || ($urandom_range(0, 99) >= 25);
   end

   // Watchdog on cycles in which neither stream moves a word.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one sample word, with random idle cycles ahead of it.
   task automatic send_sample(input logic [REQ_W-1:0] value, input logic restart);
      while (!calm && $urandom_range(0, 99) < 25) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= restart;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      board.note_sample(value, restart);
   endtask

   // Optional register write followed by a read back of the same register.
   task automatic csr_access(input bit do_write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= do_write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      if (do_write) begin
         @(posedge clock);
         csr_penable <= 1'b1;
         @(posedge clock);
         while (!csr_pready)
            @(posedge clock);
         board.write_register(addr, data);
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b0;
      end
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      if (csr_prdata !== board.register_value(addr)) begin
         $display("%0t: register at %0d expected %h, actual %h",
                  $time, addr, board.register_value(addr), csr_prdata);
         board.errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Stop sending and wait for every outstanding response word.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_config(input logic [WIN_REG_W-1:0] window, input logic [CNT_W-1:0] goal);
      drain();
      csr_access(1'b1, ADDR_WINDOW_SIZE, CSR_DATA_W'(window));
      csr_access(1'b1, ADDR_SEND_COUNT, CSR_DATA_W'(goal));
   endtask

   initial begin
      int                   count;
      int                   phase;
      int                   len;
      logic [WIN_REG_W-1:0] window;
      logic [CNT_W-1:0]     goal;
      logic [REQ_W-1:0]     value;
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset values of both registers, then extremes at the reset window.
      csr_access(1'b0, ADDR_WINDOW_SIZE, '0);
      csr_access(1'b0, ADDR_SEND_COUNT, '0);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h7FFF, 1'b1);
      send_sample(16'h8000, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h0000, 1'b0);
      send_sample(16'h0001, 1'b0);

      // Window size zero acts as one; send count zero is always due.
      set_config(7'd0, 16'd0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h7FFF, 1'b1);

      // Negative means truncate toward zero.
      set_config(7'd2, 16'hFFFF);
      send_sample(16'hFFFD, 1'b1);
      send_sample(16'h0000, 1'b0);
      send_sample(16'h0005, 1'b0);

      // Window size above the maximum acts as the maximum.
      set_config(7'd127, 16'd1);
      repeat (6) send_sample(16'h8000, 1'b0);
      send_sample(16'h7FFF, 1'b1);
      send_sample(16'h7FFF, 1'b0);

      set_config(7'd64, 16'd3);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h1234, 1'b1);
      send_sample(16'hEDCC, 1'b0);

      // Random phases, each under a fresh register setting.
      count = 0;
      phase = 0;
      while (count < RANDOM_ITEMS) begin
         case ($urandom_range(0, 7))
            0: window = 7'd0;
            1: window = 7'd1;
            2: window = 7'd64;
            3: window = WIN_REG_W'($urandom_range(65, 127));
            4: window = WIN_REG_W'($urandom_range(2, 64));
            default: window = WIN_REG_W'($urandom_range(2, 12));
         endcase
         case ($urandom_range(0, 5))
            0: goal = 16'd0;
            1: goal = 16'hFFFF;
            2: goal = CNT_W'($urandom);
            default: goal = CNT_W'($urandom_range(1, 40));
         endcase
         set_config(window, goal);
         calm = (phase == 3);
         len  = $urandom_range(40, 100);
         repeat (len) begin
            case ($urandom_range(0, 7))
               0: value = 16'h8000;
               1: value = 16'h7FFF;
               default: value = REQ_W'($urandom);
            endcase
            send_sample(value, $urandom_range(0, 19) == 0);
            count++;
         end
         phase++;
      end
      calm = 1'b0;

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ windowed_moving_average.f @@
+incdir+sv
sv/wma_pkg.sv
sv/wma_front.sv
sv/wma_fifo.sv
sv/wma_div.sv
sv/wma_back.sv
sv/windowed_moving_average.sv
tb/tb_top.sv
